/* src/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, character codes and alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	// offsets that map each alphabet range onto its sextet value
	localparam logic [7:0] LOWER_OFS  = 8'd71;  // 'a' - 26
	localparam logic [7:0] DIGIT_OFS  = 8'd4;   // 52 - '0'
	localparam logic [6:0] SEXTET_62  = 7'd62;
	localparam logic [6:0] SEXTET_63  = 7'd63;
	localparam logic [6:0] NO_SEXTET  = 7'd64;

	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	// one decoded group, as handed from the front end to the output side
	typedef struct packed {
		logic [23:0] trip;     // three bytes, first byte in the top bits
		logic [1:0]  n_bytes;  // 1..3 bytes to send
		logic        err;      // error item: one zero byte, error flag
		logic        eom;      // last byte of this group closes the message
	} job_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = NO_SEXTET;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			d = ch - CH_UPPER_A;
			r = d[6:0];
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			d = ch - LOWER_OFS;
			r = d[6:0];
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			d = ch + DIGIT_OFS;
			r = d[6:0];
		end else if (ch == CH_PLUS) begin
			r = SEXTET_62;
		end else if (ch == CH_SLASH) begin
			r = SEXTET_63;
		end
		return r;
	endfunction

endpackage

/* src/bsd_front.sv */
// ----------------------------------------------------------------------------
// bsd_front
// Character intake: classifies each character, gathers sextets and posts
// one job per group finished before any bad character, one error job per malformed message end.
// ----------------------------------------------------------------------------
module bsd_front
	import bsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       final_char,
	output logic       push,
	output job_t       job,
	output logic [1:0] grp_pos
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic        tpad_q;
	logic        failed_q;

	logic [6:0]  sval;
	logic        is_pad;
	logic        bad;
	logic        failed_nxt;
	logic [5:0]  v;
	logic [1:0]  n_final;

	always_comb begin
		sval       = sextet_of(char_code);
		is_pad     = (char_code == PAD_CHAR);
		bad        = (sval == NO_SEXTET) && !(is_pad && pos_q >= POS_THIRD);
		failed_nxt = failed_q | bad;
		v          = (sval == NO_SEXTET) ? 6'd0 : sval[5:0];
		n_final    = 2'd3 - {1'b0, tpad_q} - {1'b0, is_pad};
	end

	always_comb begin
		push         = 1'b0;
		job.trip     = {acc_q, v};
		job.n_bytes  = 2'd3;
		job.err      = 1'b0;
		job.eom      = 1'b0;
		if (accept) begin
			if (pos_q != POS_FOURTH) begin
				if (final_char) begin
					push        = 1'b1;
					job.err     = 1'b1;
					job.eom     = 1'b1;
					job.n_bytes = 2'd1;
				end
			end else if (final_char) begin
				push = 1'b1;
				job.eom = 1'b1;
				if (failed_nxt) begin
					job.err     = 1'b1;
					job.n_bytes = 2'd1;
				end else begin
					job.n_bytes = n_final;
				end
			end else begin
				push = !failed_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pos_q    <= '0;
			tpad_q   <= 1'b0;
			failed_q <= 1'b0;
		end else if (accept) begin
			if (final_char) begin
				acc_q    <= '0;
				pos_q    <= '0;
				tpad_q   <= 1'b0;
				failed_q <= 1'b0;
			end else if (pos_q != POS_FOURTH) begin
				acc_q    <= {acc_q[11:0], v};
				pos_q    <= pos_q + 2'd1;
				failed_q <= failed_nxt;
				if (pos_q == POS_THIRD) begin
					tpad_q <= is_pad;
				end
			end else begin
				acc_q    <= '0;
				pos_q    <= '0;
				tpad_q   <= 1'b0;
				failed_q <= failed_nxt;
			end
		end
	end

	assign grp_pos = pos_q;

endmodule

/* src/bsd_queue.sv */
// ----------------------------------------------------------------------------
// bsd_queue
// Short job queue between the intake and the byte output side.
// ----------------------------------------------------------------------------
module bsd_queue
	import bsd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

endmodule

/* src/bsd_back.sv */
// ----------------------------------------------------------------------------
// bsd_back
// Byte output side: unpacks the head job into bytes, one per cycle while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module bsd_back
	import bsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_error,
	output logic       end_of_message
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       err_q;
	logic       eom_q;

	logic       load;
	logic       last_byte;
	logic [7:0] sel_byte;

	always_comb begin
		load      = head_valid && (!valid_q || !out_stall);
		last_byte = (idx_q == head_job.n_bytes - 2'd1);
		pop       = load && last_byte;
		case (idx_q)
			2'd0:    sel_byte = head_job.trip[23:16];
			2'd1:    sel_byte = head_job.trip[15:8];
			default: sel_byte = head_job.trip[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last_byte ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= head_job.err ? 8'd0 : sel_byte;
			err_q  <= head_job.err;
			eom_q  <= head_job.eom && last_byte;
		end
	end

	assign out_valid      = valid_q;
	assign data_byte      = data_q;
	assign is_error       = err_q;
	assign end_of_message = eom_q;

endmodule

/* src/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 (standard alphabet) stream decoder: one character in per item,
// decoded bytes or one error item out per message end.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle, one byte per cycle, unless stalled.
// Path: the job of the character that closes a group is written into the
//   job queue on the accepting edge; its first byte then goes through the
//   output register.
// The intake stalls only when the job queue (QUEUE_DEPTH groups) is full.
// Reset (arst_n low, asynchronous) drops queued jobs and the output item
//   and starts a fresh message; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit
	import bsd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// character intake
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       final_char,
	// decoded byte output
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_error,
	output logic       end_of_message
);

	logic       accept;
	logic       push;
	job_t       push_job;
	logic       q_full;
	logic       head_valid;
	job_t       head_job;
	logic       pop;
	logic [1:0] grp_pos;

	// Intake waits only on queue space, also for characters that post no job.
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// front: alphabet lookup, sextet packing, group/message bookkeeping
	bsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (char_code),
		.final_char (final_char),
		.push       (push),
		.job        (push_job),
		.grp_pos    (grp_pos)
	);

	// decouples intake from the output stall
	bsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back: one byte per cycle into the output register while not stalled
	bsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_job       (head_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.is_error       (is_error),
		.end_of_message (end_of_message)
	);

	// error item is always a zero byte that ends the message
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_error |-> data_byte == 8'd0 && end_of_message)
		else $error("error item malformed");

	// a stalled intake means jobs are waiting for the output side
	a_stall_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> head_valid)
		else $error("intake stalled with empty queue");

	// the last character of a message leaves the group counter at zero
	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_char |=> grp_pos == 2'd0)
		else $error("group position not cleared after message end");

	// a pop only happens while the output side is taking a byte
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("job popped without a byte sent");

endmodule
